/* rtl/cllq_pkg.sv */
// shared types, field widths and codes for the circular linked queue manager
`default_nettype none

package cllq_pkg;

    // default size of the node pool
    localparam int DEF_NODES = 32;

    // item field widths
    localparam int NODE_W = 5;
    localparam int HEAD_W = 5;
    localparam int SIZE_W = 6;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 8;
    localparam int IN_PAD_W    = IN_TDATA_W - NODE_W;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + HEAD_W + SIZE_W + 1);

    // operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clear;    // clear one membership entry
        logic accept;   // take the input item and launch the link reads
        logic look;     // decide and do the first round of writes
        logic link;     // second round of writes for an append behind a tail
        logic respond;  // load the result register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // clearing pass is on its last entry
        logic need_link;  // current item needs the second write round
        logic out_free;   // result register can take a new item
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/cllq_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module cllq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cllq_ctrl.sv */
// controller state machine for the circular linked queue manager
`default_nettype none

module cllq_ctrl import cllq_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_LINK,
        ST_RESP
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_state <= i_sts.need_link ? ST_LINK : ST_RESP;
                end
                ST_LINK: begin
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.clear   = (r_state == ST_CLEAR);
        o_cmd.accept  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.look    = (r_state == ST_LOOK);
        o_cmd.link    = (r_state == ST_LINK);
        o_cmd.respond = (r_state == ST_RESP) && i_sts.out_free;
    end

endmodule

`default_nettype wire

/* rtl/cllq_dpath.sv */
// datapath: link and membership rams, head and count, result register
`default_nettype none

module cllq_dpath import cllq_pkg::*; #(
    parameter int NODES = DEF_NODES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_op,
    input  wire logic [NODE_W-1:0]      i_node,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [OUT_TDATA_W-1:0] o_out_data
);

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    logic              r_op;
    logic [IDX_W-1:0]  r_node;
    logic              r_in_range;
    logic              r_status;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_clr_idx;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;

    logic [IDX_W-1:0]  in_idx;
    logic              in_range;

    logic              next_we;
    logic [IDX_W-1:0]  next_wa;
    logic [IDX_W-1:0]  next_wd;
    logic [IDX_W-1:0]  next_ra;
    logic [IDX_W-1:0]  next_rd;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_wa;
    logic [IDX_W-1:0]  prev_wd;
    logic [IDX_W-1:0]  prev_ra;
    logic [IDX_W-1:0]  prev_rd;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [0:0]        mem_wd;
    logic [0:0]        mem_rd;

    logic              is_empty;
    logic              refuse;
    logic [CNT_W-1:0]  cnt_dec;
    logic [HEAD_W-1:0] out_head;

    // input decode
    assign in_idx   = IDX_W'(i_node);
    assign in_range = (32'(i_node) < 32'(NODES));

    // append reads the head's predecessor (the tail), remove reads the node's own
    assign next_ra = in_idx;
    assign prev_ra = (i_op == OP_APPEND) ? r_head : in_idx;

    cllq_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (next_ra),
        .o_rd_data (next_rd)
    );

    cllq_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (prev_ra),
        .o_rd_data (prev_rd)
    );

    cllq_ram #(.WIDTH(1), .DEPTH(NODES)) u_member_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (in_idx),
        .o_rd_data (mem_rd)
    );

    // decision on the registered reads
    assign is_empty = (r_count == '0);
    assign cnt_dec  = r_count - CNT_W'(1);

    always_comb begin
        if (!r_in_range) begin
            refuse = 1'b1;
        end else if (r_op == OP_APPEND) begin
            refuse = mem_rd[0];
        end else begin
            refuse = is_empty || !mem_rd[0];
        end
    end

    // write port selection
    always_comb begin
        next_we = 1'b0;
        next_wa = r_node;
        next_wd = r_node;
        prev_we = 1'b0;
        prev_wa = r_node;
        prev_wd = r_node;
        mem_we  = 1'b0;
        mem_wa  = r_node;
        mem_wd  = 1'b0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_idx;
            mem_wd = 1'b0;
        end else if (i_cmd.look && !refuse) begin
            mem_we  = 1'b1;
            mem_wd  = (r_op == OP_APPEND);
            next_we = 1'b1;
            prev_we = 1'b1;
            if (r_op == OP_APPEND) begin
                if (!is_empty) begin
                    // tail -> node, node <- tail
                    next_wa = prev_rd;
                    next_wd = r_node;
                    prev_wa = r_node;
                    prev_wd = prev_rd;
                end
            end else begin
                // bridge predecessor and successor
                next_wa = prev_rd;
                next_wd = next_rd;
                prev_wa = next_rd;
                prev_wd = prev_rd;
            end
        end else if (i_cmd.link) begin
            // node -> head, head <- node
            next_we = 1'b1;
            next_wa = r_node;
            next_wd = r_head;
            prev_we = 1'b1;
            prev_wa = r_head;
            prev_wd = r_node;
        end
    end

    // head and count
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.look && !refuse) begin
            if (r_op == OP_APPEND) begin
                n_count = r_count + CNT_W'(1);
                if (is_empty) begin
                    n_head = r_node;
                end
            end else if ((next_rd == r_node) || (cnt_dec == '0)) begin
                n_count = '0;
                n_head  = '0;
            end else begin
                n_count = cnt_dec;
                if (r_node == r_head) begin
                    n_head = next_rd;
                end
            end
        end
    end

    assign out_head = is_empty ? '0 : HEAD_W'(r_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_op;
            r_node     <= in_idx;
            r_in_range <= in_range;
        end
        if (i_cmd.look) begin
            r_status <= refuse ? STATUS_REFUSED : STATUS_DONE;
        end
        if (i_cmd.respond) begin
            r_out_data <= {OUT_PAD_W'(0), is_empty, SIZE_W'(r_count), out_head, r_status};
        end
    end

    assign o_sts.clr_last  = (r_clr_idx == IDX_W'(NODES - 1));
    assign o_sts.need_link = (r_op == OP_APPEND) && !is_empty && !refuse;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/circular_linked_queue_manager.sv */
// top level of the circular doubly linked queue manager
`default_nettype none

// Keeps a circular doubly linked queue over a pool of NODES node numbers and
// answers every item with exactly one result. An item with op append puts the
// node at the tail (just ahead of the head); it is refused if the node is
// already queued. An item with op remove unlinks any queued node, moving the
// head on to its successor when the head itself goes; removing from an empty
// queue or removing a node that is not queued is refused, as is any node
// number not below NODES. Each result carries status, the head after the item
// (zero while the queue is empty), the size and an empty flag. Next and
// previous links and the membership bits sit in three small rams with one
// write and one registered read port each, so an accepted item passes a look
// state and then a result state, with a link state between them for an append
// to a queue that already holds nodes, where the second pair of link writes
// has to wait for the single write port. With the result register free the
// input reopens on the next cycle. One item is in work at a time; the result
// register lets the next item in while the previous result waits. After reset
// the membership ram is swept clear, one entry a cycle, over all NODES entries,
// during which s_axis_tready stays low.
module circular_linked_queue_manager import cllq_pkg::*; #(
    parameter int NODES = DEF_NODES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [4:0] node, [7:5] zero
    input  wire logic [0:0]             s_axis_tuser,  // [0] op
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // [0] status, [5:1] head,
                                                       // [11:6] size, [12] empty_res,
                                                       // [15:13] zero
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing of clear pass, reads, write rounds and result
    cllq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // link tables, membership, head, count and result register
    cllq_dpath #(.NODES(NODES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_op        (s_axis_tuser[0]),
        .i_node      (s_axis_tdata[NODE_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // an accepted item keeps the input closed while it is in work
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // empty flag agrees with the size
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12] == (m_axis_tdata[11:6] == 6'd0)))
        else $error("empty flag disagrees with size");

    // an empty queue reports head zero
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> (m_axis_tdata[5:1] == 5'd0))
        else $error("empty queue reports a head");

    // size never exceeds the pool
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (NODES > 63) || (32'(m_axis_tdata[11:6]) <= 32'(NODES)))
        else $error("size beyond node pool");

endmodule

`default_nettype wire

/* bench/circular_linked_queue_manager_test.sv */
// self-checking stream testbench for the circular linked queue manager
`timescale 1ns / 1ps

module circular_linked_queue_manager_test import cllq_pkg::*; ();

    localparam int POOL         = DEF_NODES;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DIRECTED_N   = 21;

    // one result item as the block reports it
    typedef struct packed {
        logic              status;
        logic [HEAD_W-1:0] head;
        logic [SIZE_W-1:0] size;
        logic              empty_res;
    } t_reply;

    // one directed step: typed rows carry their own expected reply
    typedef struct packed {
        logic              op;
        logic [NODE_W-1:0] node;
        logic              typed;
        t_reply            want;
    } t_step;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [4:0] node, [7:5] zero
    logic [0:0]             s_axis_tuser;   // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] status, [5:1] head, [11:6] size,
                                            // [12] empty_res, [15:13] zero

    // shadow copy of the queue, kept up to date on every accepted item
    logic [NODE_W-1:0] q_next [POOL];
    logic [NODE_W-1:0] q_prev [POOL];
    bit                q_member [POOL];
    logic [NODE_W-1:0] q_head;
    logic [SIZE_W-1:0] q_count;

    t_reply pending_replies [$];
    int     fail_count;
    int     burst_left;

    // walk through every special case with small, readable numbers
    t_step directed_steps [DIRECTED_N] = '{
        '{OP_REMOVE, 5'd0,  1'b1, '{STATUS_REFUSED, 5'd0,  6'd0, 1'b1}}, // remove from empty
        '{OP_APPEND, 5'd0,  1'b1, '{STATUS_DONE,    5'd0,  6'd1, 1'b0}}, // append to empty
        '{OP_APPEND, 5'd0,  1'b1, '{STATUS_REFUSED, 5'd0,  6'd1, 1'b0}}, // append of member
        '{OP_APPEND, 5'd31, 1'b1, '{STATUS_DONE,    5'd0,  6'd2, 1'b0}},
        '{OP_APPEND, 5'd16, 1'b0, '0},
        '{OP_APPEND, 5'd1,  1'b0, '0},
        '{OP_REMOVE, 5'd16, 1'b0, '0},                                   // middle node
        '{OP_REMOVE, 5'd7,  1'b1, '{STATUS_REFUSED, 5'd0,  6'd3, 1'b0}}, // non-member
        '{OP_REMOVE, 5'd0,  1'b0, '0},                                   // head moves on
        '{OP_REMOVE, 5'd1,  1'b0, '0},                                   // tail goes
        '{OP_APPEND, 5'd31, 1'b1, '{STATUS_REFUSED, 5'd31, 6'd1, 1'b0}},
        '{OP_REMOVE, 5'd31, 1'b1, '{STATUS_DONE,    5'd0,  6'd0, 1'b1}}, // only node goes
        '{OP_REMOVE, 5'd31, 1'b1, '{STATUS_REFUSED, 5'd0,  6'd0, 1'b1}},
        '{OP_APPEND, 5'd31, 1'b1, '{STATUS_DONE,    5'd31, 6'd1, 1'b0}},
        '{OP_APPEND, 5'd0,  1'b0, '0},
        '{OP_APPEND, 5'd21, 1'b0, '0},
        '{OP_APPEND, 5'd10, 1'b0, '0},
        '{OP_REMOVE, 5'd31, 1'b0, '0},
        '{OP_REMOVE, 5'd0,  1'b0, '0},
        '{OP_REMOVE, 5'd21, 1'b0, '0},
        '{OP_REMOVE, 5'd10, 1'b1, '{STATUS_DONE,    5'd0,  6'd0, 1'b1}}
    };

    circular_linked_queue_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // apply one item to the shadow queue and give the reply it must produce
    function automatic t_reply apply_queue_op(input logic op, input logic [NODE_W-1:0] n);
        t_reply            r;
        logic [NODE_W-1:0] p;
        logic [NODE_W-1:0] s;
        r.status = STATUS_REFUSED;
        if (op == OP_APPEND) begin
            if (!q_member[n]) begin
                if (q_count == 0) begin
                    q_head    = n;
                    q_next[n] = n;
                    q_prev[n] = n;
                end else begin
                    p              = q_prev[q_head];
                    q_next[p]      = n;
                    q_prev[n]      = p;
                    q_next[n]      = q_head;
                    q_prev[q_head] = n;
                end
                q_member[n] = 1'b1;
                q_count     = q_count + 1'b1;
                r.status    = STATUS_DONE;
            end
        end else if (q_count != 0 && q_member[n]) begin
            p         = q_prev[n];
            s         = q_next[n];
            q_next[p] = s;
            q_prev[s] = p;
            if (n == q_head)
                q_head = s;
            q_member[n] = 1'b0;
            q_count     = q_count - 1'b1;
            if (s == n || q_count == 0) begin
                q_count = '0;
                q_head  = '0;
            end
            r.status = STATUS_DONE;
        end
        r.head      = (q_count == 0) ? '0 : q_head;
        r.size      = q_count;
        r.empty_res = (q_count == 0);
        return r;
    endfunction

    // present one item, wait for its handshake, then keep up the burst pattern
    task automatic offer_item(input logic op, input logic [NODE_W-1:0] n,
                              input logic typed, input t_reply want);
        t_reply predicted;
        int     gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, n};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_queue_op(op, n);
        pending_replies.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 5);
            // a gap of zero keeps tvalid high into the next burst
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(0, 7);
        end
    endtask

    // result side: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result item with nothing expected: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tdata[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[5:1] !== want.head) begin
                    $error("head: expected %0d, got %0d", want.head, m_axis_tdata[5:1]);
                    fail_count++;
                end
                if (m_axis_tdata[11:6] !== want.size) begin
                    $error("size: expected %0d, got %0d", want.size, m_axis_tdata[11:6]);
                    fail_count++;
                end
                if (m_axis_tdata[12] !== want.empty_res) begin
                    $error("empty_res: expected %0d, got %0d",
                           want.empty_res, m_axis_tdata[12]);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure: repeated 16-bit ready patterns, from never stalling to mostly stalled
    initial begin
        logic [15:0] stall_pattern;
        int          i;
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = 16'($urandom);
                2:       stall_pattern = 16'($urandom & $urandom);
                default: stall_pattern = 16'($urandom | $urandom);
            endcase
            if (stall_pattern == '0)
                stall_pattern = 16'h0001;
            repeat ($urandom_range(2, 8)) begin
                for (i = 0; i < 16; i++) begin
                    m_axis_tready <= stall_pattern[i];
                    @(posedge i_clk);
                end
            end
        end
    end

    // guard against a hung block
    initial begin
        #5ms;
        $display("circular_linked_queue_manager test failed");
        $finish;
    end

    initial begin
        int                k;
        int                sent;
        int                seg_len;
        int                append_pct;
        logic              op;
        logic [NODE_W-1:0] n;
        fail_count = 0;
        burst_left = 0;
        for (k = 0; k < POOL; k++) begin
            q_next[k]   = '0;
            q_prev[k]   = '0;
            q_member[k] = 1'b0;
        end
        q_head  = '0;
        q_count = '0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_N; k++)
            offer_item(directed_steps[k].op, directed_steps[k].node,
                       directed_steps[k].typed, directed_steps[k].want);

        // random part in segments that lean towards filling, draining or churning
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       append_pct = 95;
                1:       append_pct = 10;
                default: append_pct = 55;
            endcase
            seg_len = $urandom_range(30, 80);
            for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_REMOVE;
                n  = NODE_W'($urandom_range(0, POOL - 1));
                // mostly sensible picks, the odd refused one as noise
                if ($urandom_range(0, 9) != 0) begin
                    if (op == OP_APPEND && q_count < POOL)
                        while (q_member[n]) n = NODE_W'($urandom_range(0, POOL - 1));
                    else if (op == OP_REMOVE && q_count != 0)
                        while (!q_member[n]) n = NODE_W'($urandom_range(0, POOL - 1));
                end
                offer_item(op, n, 1'b0, '0);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0)
            $display("circular_linked_queue_manager test passed");
        else
            $display("circular_linked_queue_manager test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/cllq_pkg.sv
rtl/cllq_ram.sv
rtl/cllq_ctrl.sv
rtl/cllq_dpath.sv
rtl/circular_linked_queue_manager.sv
bench/circular_linked_queue_manager_test.sv
